/* rtl/core/hsvrgb_pkg.sv */
// Shared constants, widths and types for the HSV to RGB pixel converter.
// Used by hsvrgb_chan and hsv_to_rgb_pixel; depends on nothing.
package hsvrgb_pkg;

    // Input formats
    localparam int HUE_W = 15;
    localparam int UNIT_W = 17;
    localparam int RGB_W = 8;

    localparam logic [HUE_W-1:0]  HUE_TURN   = 15'd23040;
    localparam int                HUE_SECTOR = 3840;
    localparam logic [UNIT_W-1:0] ONE_Q16    = 17'd65536;

    // Internal widths
    localparam int SECT_W = 3;      // sector 0..5
    localparam int FRAC_W = 12;     // offset within a sector, 0..3840
    localparam int PROD_W = 33;     // S*V and V - S*V, up to 2^32
    localparam int CHAN_W = 44;     // channel level in units of 1/(2^32*3840)
    localparam int SCALED_W = 53;   // 510*n + D
    localparam int SHIFT_LO = 41;   // 2D = 15 * 2^41
    localparam int QUOT_W = 12;     // floor((510n + D) / 2^41), at most 3839
    localparam int RECIP_W = 16;
    localparam int RECIP_SH = 19;
    localparam logic [RECIP_W-1:0] RECIP_15 = 16'd34953;   // ceil(2^19 / 15)
    localparam logic [SCALED_W-1:0] ROUND_D = 53'd16492674416640; // 2^32 * 3840
    localparam logic [RGB_W-1:0] FULL_SCALE = 8'd255;

    // Hue sectors
    localparam logic [SECT_W-1:0] SECT_RY = 3'd0;
    localparam logic [SECT_W-1:0] SECT_YG = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GC = 3'd2;
    localparam logic [SECT_W-1:0] SECT_CB = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BM = 3'd4;

    // Load enables for the three per-channel stages
    typedef struct packed {
        logic ld_sum;
        logic ld_scale;
        logic ld_byte;
    } chan_load_t;

endpackage

/* rtl/core/hsvrgb_chan.sv */
// One color channel: adds the M term, scales by 255 and rounds to a byte.
// Three register stages under load enables from the top level; uses hsvrgb_pkg.
module hsvrgb_chan (
    input  logic                                  clk,
    input  hsvrgb_pkg::chan_load_t                load,
    input  logic [hsvrgb_pkg::CHAN_W-1:0]         part,
    input  logic [hsvrgb_pkg::PROD_W-1:0]         base,
    output logic [hsvrgb_pkg::RGB_W-1:0]          level
);

    logic [hsvrgb_pkg::CHAN_W-1:0]   sum_reg, sum_next;
    logic [hsvrgb_pkg::QUOT_W-1:0]   quot_reg, quot_next;
    logic [hsvrgb_pkg::RGB_W-1:0]    byte_reg, byte_next;
    logic [hsvrgb_pkg::CHAN_W-1:0]   base_sc;
    logic [hsvrgb_pkg::SCALED_W-1:0] sum_w, scaled;
    logic [hsvrgb_pkg::QUOT_W+hsvrgb_pkg::RECIP_W-1:0] recip_prod;
    logic [hsvrgb_pkg::QUOT_W+hsvrgb_pkg::RECIP_W-hsvrgb_pkg::RECIP_SH-1:0] div15;

    always_comb
    begin
        // base * 3840 = base*4096 - base*256
        base_sc  = (hsvrgb_pkg::CHAN_W'(base) << 12) - (hsvrgb_pkg::CHAN_W'(base) << 8);
        sum_next = part + base_sc;

        // 510*n + D, then drop 2^41
        sum_w     = hsvrgb_pkg::SCALED_W'(sum_reg);
        scaled    = (sum_w << 9) - (sum_w << 1) + hsvrgb_pkg::ROUND_D;
        quot_next = scaled[hsvrgb_pkg::SCALED_W-1:hsvrgb_pkg::SHIFT_LO];

        // divide by 15 through the reciprocal, exact below 3840
        recip_prod = hsvrgb_pkg::QUOT_W'(quot_reg) * hsvrgb_pkg::RECIP_15;
        div15      = recip_prod[hsvrgb_pkg::QUOT_W+hsvrgb_pkg::RECIP_W-1:hsvrgb_pkg::RECIP_SH];
        if (div15 > (hsvrgb_pkg::QUOT_W+hsvrgb_pkg::RECIP_W-hsvrgb_pkg::RECIP_SH)'
                (hsvrgb_pkg::FULL_SCALE))
        begin
            byte_next = hsvrgb_pkg::FULL_SCALE;
        end
        else
        begin
            byte_next = div15[hsvrgb_pkg::RGB_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.ld_sum)
        begin
            sum_reg <= sum_next;
        end
        if (load.ld_scale)
        begin
            quot_reg <= quot_next;
        end
        if (load.ld_byte)
        begin
            byte_reg <= byte_next;
        end
    end

    assign level = byte_reg;

endmodule

/* rtl/core/hsv_to_rgb_pixel.sv */
// HSV to 8-bit RGB pixel converter, six register stages with per-stage valid.
// Throughput: one item per cycle while out_ready stays high; each stage loads
// when it is empty or its item moves on, so bubbles close up under output
// stall and nothing is lost or repeated.
// Reset (rst_n, async, active low) clears only the stage valid bits.
// Uses hsvrgb_pkg and three hsvrgb_chan instances for the final stages.
module hsv_to_rgb_pixel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]      hue,
    input  logic [hsvrgb_pkg::UNIT_W-1:0]     saturation,
    input  logic [hsvrgb_pkg::UNIT_W-1:0]     brightness,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hsvrgb_pkg::RGB_W-1:0]      red,
    output logic [hsvrgb_pkg::RGB_W-1:0]      green,
    output logic [hsvrgb_pkg::RGB_W-1:0]      blue
);

    localparam int NSTAGE = 6;

    // Stage valid bits (index 0 is stage 1) and load enables
    logic [NSTAGE-1:0] vld_reg, vld_next;
    logic [NSTAGE-1:0] load;
    hsvrgb_pkg::chan_load_t chan_load;

    // Stage 1: wrapped hue split into sector and offset, clamped S and V
    logic [hsvrgb_pkg::SECT_W-1:0] sect1_reg, sect1_next;
    logic [hsvrgb_pkg::FRAC_W-1:0] k1_reg, k1_next;
    logic [hsvrgb_pkg::UNIT_W-1:0] sat1_reg, sat1_next;
    logic [hsvrgb_pkg::UNIT_W-1:0] val1_reg, val1_next;
    logic [hsvrgb_pkg::HUE_W-1:0]  hue_wrap, sect_start;
    logic [hsvrgb_pkg::FRAC_W-1:0] frac;

    // Stage 2: chroma C = S*V
    logic [hsvrgb_pkg::SECT_W-1:0] sect2_reg;
    logic [hsvrgb_pkg::FRAC_W-1:0] k2_reg;
    logic [hsvrgb_pkg::UNIT_W-1:0] val2_reg;
    logic [hsvrgb_pkg::PROD_W-1:0] chroma2_reg, chroma2_next;
    logic [2*hsvrgb_pkg::UNIT_W-1:0] sv_prod;

    // Stage 3: M base, X and C scaled to common units, channel parts placed
    logic [hsvrgb_pkg::PROD_W-1:0] mbase3_reg, mbase3_next;
    logic [hsvrgb_pkg::CHAN_W-1:0] r3_reg, g3_reg, b3_reg;
    logic [hsvrgb_pkg::CHAN_W-1:0] r3_next, g3_next, b3_next;
    logic [hsvrgb_pkg::PROD_W+hsvrgb_pkg::FRAC_W-1:0] x_prod;
    logic [hsvrgb_pkg::CHAN_W-1:0] x_term, c_term, c_wide;

    // Ready chain: a stage loads when empty or when its item moves on
    always_comb
    begin
        load[NSTAGE-1] = !vld_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
        vld_next = vld_reg;
        if (load[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (load[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = vld_reg[NSTAGE-1];

    // Stage 1 logic: wrap hue into one turn, find its sector by compare
    always_comb
    begin
        hue_wrap = (hue >= hsvrgb_pkg::HUE_TURN) ? (hue - hsvrgb_pkg::HUE_TURN) : hue;
        sect1_next = '0;
        sect_start = '0;
        for (int i = 1; i < 6; i++)
        begin
            if (hue_wrap >= hsvrgb_pkg::HUE_W'(i * hsvrgb_pkg::HUE_SECTOR))
            begin
                sect1_next = hsvrgb_pkg::SECT_W'(i);
                sect_start = hsvrgb_pkg::HUE_W'(i * hsvrgb_pkg::HUE_SECTOR);
            end
        end
        frac = hsvrgb_pkg::FRAC_W'(hue_wrap - sect_start);
        // Odd sectors fall, even sectors rise
        k1_next = sect1_next[0] ? (hsvrgb_pkg::FRAC_W'(hsvrgb_pkg::HUE_SECTOR) - frac)
                                : frac;
        sat1_next = (saturation > hsvrgb_pkg::ONE_Q16) ? hsvrgb_pkg::ONE_Q16 : saturation;
        val1_next = (brightness > hsvrgb_pkg::ONE_Q16) ? hsvrgb_pkg::ONE_Q16 : brightness;
    end

    // Stage 2 logic: one 17x17 multiply
    always_comb
    begin
        sv_prod      = sat1_reg * val1_reg;
        chroma2_next = sv_prod[hsvrgb_pkg::PROD_W-1:0];
    end

    // Stage 3 logic: X = C*k, C*3840, M = V*2^16 - C, place by sector
    always_comb
    begin
        x_prod = chroma2_reg * k2_reg;
        x_term = x_prod[hsvrgb_pkg::CHAN_W-1:0];
        c_wide = hsvrgb_pkg::CHAN_W'(chroma2_reg);
        c_term = (c_wide << 12) - (c_wide << 8);
        mbase3_next = ({val2_reg, 16'd0}) - chroma2_reg;

        r3_next = '0;
        g3_next = '0;
        b3_next = '0;
        case (sect2_reg)
            hsvrgb_pkg::SECT_RY:
            begin
                r3_next = c_term;
                g3_next = x_term;
            end
            hsvrgb_pkg::SECT_YG:
            begin
                r3_next = x_term;
                g3_next = c_term;
            end
            hsvrgb_pkg::SECT_GC:
            begin
                g3_next = c_term;
                b3_next = x_term;
            end
            hsvrgb_pkg::SECT_CB:
            begin
                g3_next = x_term;
                b3_next = c_term;
            end
            hsvrgb_pkg::SECT_BM:
            begin
                r3_next = x_term;
                b3_next = c_term;
            end
            default:
            begin
                r3_next = c_term;
                b3_next = x_term;
            end
        endcase
    end

    // Payload registers: hold unless the stage loads
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            sect1_reg <= sect1_next;
            k1_reg    <= k1_next;
            sat1_reg  <= sat1_next;
            val1_reg  <= val1_next;
        end
        if (load[1])
        begin
            sect2_reg   <= sect1_reg;
            k2_reg      <= k1_reg;
            val2_reg    <= val1_reg;
            chroma2_reg <= chroma2_next;
        end
        if (load[2])
        begin
            mbase3_reg <= mbase3_next;
            r3_reg     <= r3_next;
            g3_reg     <= g3_next;
            b3_reg     <= b3_next;
        end
    end

    // Stages 4 to 6 live in the channel units
    assign chan_load.ld_sum   = load[3];
    assign chan_load.ld_scale = load[4];
    assign chan_load.ld_byte  = load[5];

    hsvrgb_chan u_red (
        .clk   (clk),
        .load  (chan_load),
        .part  (r3_reg),
        .base  (mbase3_reg),
        .level (red)
    );

    hsvrgb_chan u_green (
        .clk   (clk),
        .load  (chan_load),
        .part  (g3_reg),
        .base  (mbase3_reg),
        .level (green)
    );

    hsvrgb_chan u_blue (
        .clk   (clk),
        .load  (chan_load),
        .part  (b3_reg),
        .base  (mbase3_reg),
        .level (blue)
    );

endmodule

/* dv/hsv_to_rgb_pixel_tb.sv */
// Self-checking testbench for the hsv_to_rgb_pixel HSV to 8-bit RGB converter.
// Depends on hsvrgb_pkg for port widths and sector codes, and on the converter RTL.
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_tb;

    // Run-length guard and the length of the long output hold-off.
    localparam int TIMEOUT_NS  = 2_000_000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_WAIT  = 12;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [hsvrgb_pkg::RGB_W-1:0] red;
        logic [hsvrgb_pkg::RGB_W-1:0] green;
        logic [hsvrgb_pkg::RGB_W-1:0] blue;
    } rgb_t;

    // Clock, reset and every block input start at known values.
    logic                             clk        = 1'b0;
    logic                             rst_n      = 1'b0;
    logic                             in_valid   = 1'b0;
    logic [hsvrgb_pkg::HUE_W-1:0]     hue        = '0;
    logic [hsvrgb_pkg::UNIT_W-1:0]    saturation = '0;
    logic [hsvrgb_pkg::UNIT_W-1:0]    brightness = '0;
    logic                             out_ready  = 1'b0;
    logic                             in_ready;
    logic                             out_valid;
    logic [hsvrgb_pkg::RGB_W-1:0]     red;
    logic [hsvrgb_pkg::RGB_W-1:0]     green;
    logic [hsvrgb_pkg::RGB_W-1:0]     blue;

    // Expected colors, oldest first, plus run bookkeeping.
    rgb_t pending_rgb[$];
    int   pixels_sent      = 0;
    int   pixels_checked   = 0;
    int   mismatch_cnt     = 0;
    int   input_stall_cnt  = 0;

    // Idle percentages per side; the phase tasks set them.
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic rx_holding   = 1'b0;
    event hold_start;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    hsv_to_rgb_pixel u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    // Scale a channel level (units of 1/(2^32*3840)) by 255 and round,
    // halves up: floor((510*n + D) / 2D).
    function automatic logic [hsvrgb_pkg::RGB_W-1:0] level_to_byte(input logic [63:0] lvl);
        logic [63:0] den;
        logic [63:0] q;
        den = (64'd1 << 32) * 64'd3840;
        q = (64'd510 * lvl + den) / (64'd2 * den);
        return (q > 64'd255) ? hsvrgb_pkg::FULL_SCALE : q[hsvrgb_pkg::RGB_W-1:0];
    endfunction

    // Exact integer HSV to RGB: wrap hue into one turn, clamp S and V to 1.0,
    // build chroma, the ramp channel and the floor, then place by sector.
    function automatic rgb_t convert_hsv(input logic [hsvrgb_pkg::HUE_W-1:0]  h_in,
                                         input logic [hsvrgb_pkg::UNIT_W-1:0] s_in,
                                         input logic [hsvrgb_pkg::UNIT_W-1:0] v_in);
        logic [63:0] h, s, v, sect, frac, ramp;
        logic [63:0] c_lvl, x_lvl, m_lvl, r_lvl, g_lvl, b_lvl;
        rgb_t        px;
        h = 64'(h_in);
        if (h >= 64'(hsvrgb_pkg::HUE_TURN))
            h = h - 64'(hsvrgb_pkg::HUE_TURN);
        s = (s_in > hsvrgb_pkg::ONE_Q16) ? 64'(hsvrgb_pkg::ONE_Q16) : 64'(s_in);
        v = (v_in > hsvrgb_pkg::ONE_Q16) ? 64'(hsvrgb_pkg::ONE_Q16) : 64'(v_in);
        sect = h / 64'(hsvrgb_pkg::HUE_SECTOR);
        frac = h % 64'(hsvrgb_pkg::HUE_SECTOR);
        // Rising ramp in even sectors, falling in odd ones.
        ramp = sect[0] ? 64'(hsvrgb_pkg::HUE_SECTOR) - frac : frac;
        c_lvl = s * v * 64'(hsvrgb_pkg::HUE_SECTOR);
        x_lvl = s * v * ramp;
        m_lvl = v * 64'(hsvrgb_pkg::ONE_Q16) * 64'(hsvrgb_pkg::HUE_SECTOR) - c_lvl;
        r_lvl = '0;
        g_lvl = '0;
        b_lvl = '0;
        case (sect[hsvrgb_pkg::SECT_W-1:0])
            hsvrgb_pkg::SECT_RY: begin r_lvl = c_lvl; g_lvl = x_lvl; end
            hsvrgb_pkg::SECT_YG: begin r_lvl = x_lvl; g_lvl = c_lvl; end
            hsvrgb_pkg::SECT_GC: begin g_lvl = c_lvl; b_lvl = x_lvl; end
            hsvrgb_pkg::SECT_CB: begin g_lvl = x_lvl; b_lvl = c_lvl; end
            hsvrgb_pkg::SECT_BM: begin r_lvl = x_lvl; b_lvl = c_lvl; end
            default:             begin r_lvl = c_lvl; b_lvl = x_lvl; end
        endcase
        px.red   = level_to_byte(r_lvl + m_lvl);
        px.green = level_to_byte(g_lvl + m_lvl);
        px.blue  = level_to_byte(b_lvl + m_lvl);
        return px;
    endfunction

    // Pick a Q1.16 unit value: mostly in range, with the ends and
    // out-of-range values (which clamp to 1.0) mixed in.
    function automatic logic [hsvrgb_pkg::UNIT_W-1:0] pick_unit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return hsvrgb_pkg::ONE_Q16;
            2:       return hsvrgb_pkg::UNIT_W'($urandom_range(131071, 65537));
            default: return hsvrgb_pkg::UNIT_W'($urandom_range(65536));
        endcase
    endfunction

    // Offer one pixel. Idle the input first at the current rate, then hold
    // valid and payload until the handshake, and queue the predicted color.
    task automatic send_pixel(input logic [hsvrgb_pkg::HUE_W-1:0]  h,
                              input logic [hsvrgb_pkg::UNIT_W-1:0] s,
                              input logic [hsvrgb_pkg::UNIT_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            input_stall_cnt++;
            @(posedge clk);
        end
        pending_rgb.push_back(convert_hsv(h, s, v));
        pixels_sent++;
    endtask

    // Random pixel: hue mostly within one turn, some exactly on a sector
    // boundary, some past the turn so the wrap gets exercised.
    task automatic send_random();
        logic [hsvrgb_pkg::HUE_W-1:0] h;
        case ($urandom_range(9))
            0:       h = hsvrgb_pkg::HUE_W'($urandom_range(32767, 23040));
            1:       h = hsvrgb_pkg::HUE_W'($urandom_range(5) * hsvrgb_pkg::HUE_SECTOR);
            default: h = hsvrgb_pkg::HUE_W'($urandom_range(23039));
        endcase
        send_pixel(h, pick_unit(), pick_unit());
    endtask

    // Drop valid and wait until every queued color has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rgb.size() != 0)
            @(posedge clk);
    endtask

    // Sector boundaries and midpoints at full S and V, hue wrap,
    // clamped S and V, black, grey and the exact half rounding case.
    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_pixel(15'd0,     17'd65536,  17'd65536);
        send_pixel(15'd3839,  17'd65536,  17'd65536);
        send_pixel(15'd3840,  17'd65536,  17'd65536);
        send_pixel(15'd7680,  17'd65536,  17'd65536);
        send_pixel(15'd11520, 17'd65536,  17'd65536);
        send_pixel(15'd15360, 17'd65536,  17'd65536);
        send_pixel(15'd19200, 17'd65536,  17'd65536);
        send_pixel(15'd23039, 17'd65536,  17'd65536);
        send_pixel(15'd1920,  17'd65536,  17'd65536);
        send_pixel(15'd5760,  17'd65536,  17'd65536);
        send_pixel(15'd9600,  17'd65536,  17'd65536);
        send_pixel(15'd13440, 17'd65536,  17'd65536);
        send_pixel(15'd17280, 17'd65536,  17'd65536);
        send_pixel(15'd21120, 17'd65536,  17'd65536);
        // Hue past one turn wraps back into the first turn.
        send_pixel(15'd23040, 17'd65536,  17'd65536);
        send_pixel(15'd32767, 17'd40000,  17'd50000);
        // No saturation gives grey, no brightness gives black.
        send_pixel(15'd5000,  17'd0,      17'd65536);
        send_pixel(15'd5000,  17'd65536,  17'd0);
        // Saturation and brightness above one clamp to one.
        send_pixel(15'd5000,  17'd131071, 17'd131071);
        send_pixel(15'd12345, 17'd65537,  17'd70000);
        send_pixel(15'd20000, 17'd1,      17'd1);
        // Grey at half brightness lands on 127.5 and rounds up.
        send_pixel(15'd0,     17'd0,      17'd32768);
    endtask

    task automatic test_streaming();
        int i;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        for (i = 0; i < 430; i++)
            send_random();
    endtask

    task automatic test_sender_gaps();
        int i;
        tx_idle_pct  = 46;
        rx_stall_pct = 0;
        for (i = 0; i < 300; i++)
            send_random();
    endtask

    task automatic test_receiver_stalls();
        int i;
        tx_idle_pct  = 0;
        rx_stall_pct = 46;
        for (i = 0; i < 300; i++)
            send_random();
    endtask

    task automatic test_both_idle();
        int i;
        tx_idle_pct  = 10;
        rx_stall_pct = 10;
        for (i = 0; i < 300; i++)
            send_random();
    endtask

    // Hold the output off for a long stretch while the input keeps
    // offering items, so the pipeline fills and stalls its input.
    task automatic test_backpressure();
        int i;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        -> hold_start;
        for (i = 0; i < 300; i++)
            send_random();
    endtask

    // Short bursts, each followed by a full drain before the next.
    task automatic test_drain_pause();
        int burst;
        int i;
        tx_idle_pct  = 10;
        rx_stall_pct = 10;
        for (burst = 0; burst < 3; burst++)
        begin
            for (i = 0; i < 50; i++)
                send_random();
            wait_drained();
        end
    endtask

    // Count out the long hold-off in its own process.
    initial
    begin
        forever
        begin
            @(hold_start);
            @(posedge clk);
            rx_holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_holding <= 1'b0;
        end
    end

    // Output side: check each accepted color against the oldest prediction,
    // then pick the next cycle's ready from the stall rate and the hold-off.
    always @(posedge clk)
    begin : rx_side
        rgb_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_rgb.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected color r=%0d g=%0d b=%0d",
                                 $realtime, red, green, blue);
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    pixels_checked++;
                    if (red !== want.red || green !== want.green || blue !== want.blue)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"%0t: color %0d mismatch: exp r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     $realtime, pixels_checked - 1,
                                     want.red, want.green, want.blue, red, green, blue);
                    end
                end
            end
            out_ready <= !rx_holding && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Hard stop in case the pipeline hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d colors outstanding", pending_rgb.size());
        $display("hsv_to_rgb_pixel_tb failed");
        $finish;
    end

    initial
    begin
        // Hold reset low, then release it on a clock edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();
        test_drain_pause();

        // Drain, then give the pipeline time to show any stray result.
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Converted %0d pixels over all six hue sectors, wrapped hue and clamped S/V;",
                 pixels_sent);
        $display("%0d colors checked, input held off %0d cycles, %0d mismatches",
                 pixels_checked, input_stall_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_rgb.size() == 0)
            $display("hsv_to_rgb_pixel_tb passed");
        else
            $display("hsv_to_rgb_pixel_tb failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_chan.sv
rtl/core/hsv_to_rgb_pixel.sv
dv/hsv_to_rgb_pixel_tb.sv
